// ===== hw/rtl/rtnh_pkg.sv =====
// Shared types and constants of the ray/triangle nearest-hit block.
// Holds the port payload structs, register indexes and the micro-op table.
// No dependencies.
package rtnh_pkg;

    localparam int WORD_W = 32;
    localparam int DIST_W = 31;
    localparam int EPS_W  = 16;
    localparam int BARY_W = 17;
    localparam int OUT_IDX_W = 16;
    localparam int ACC_W = 66;
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_DET_LAST = 5'd8;
    localparam logic [STEP_W-1:0] STEP_Q_FIRST  = 5'd9;
    localparam logic [STEP_W-1:0] STEP_LAST     = 5'd23;
    localparam logic [DIST_W-1:0] DIST_MAX = 31'h7FFF_FFFF;

    typedef enum logic [2:0] {
        REG_ORIGIN_X  = 3'd0,
        REG_ORIGIN_Y  = 3'd1,
        REG_ORIGIN_Z  = 3'd2,
        REG_DIR_X     = 3'd3,
        REG_DIR_Y     = 3'd4,
        REG_DIR_Z     = 3'd5,
        REG_MAX_DIST  = 3'd6,
        REG_EPSILON   = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] a_x;
        logic signed [WORD_W-1:0] a_y;
        logic signed [WORD_W-1:0] a_z;
        logic signed [WORD_W-1:0] b_x;
        logic signed [WORD_W-1:0] b_y;
        logic signed [WORD_W-1:0] b_z;
        logic signed [WORD_W-1:0] c_x;
        logic signed [WORD_W-1:0] c_y;
        logic signed [WORD_W-1:0] c_z;
        logic                     skip_triangle;
        logic                     batch_end;
    } tri_t;

    typedef struct packed {
        logic                 tri_hit;
        logic [DIST_W-1:0]    tri_distance;
        logic [BARY_W-1:0]    tri_u;
        logic [BARY_W-1:0]    tri_v;
        logic                 nearest_updated;
        logic                 nearest_found;
        logic [DIST_W-1:0]    nearest_distance;
        logic [OUT_IDX_W-1:0] nearest_index;
        logic                 batch_done;
    } res_t;

    typedef struct packed {
        logic neg;
        logic first;
        logic last;
    } mac_ctl_t;

    typedef enum logic [4:0] {
        OP_DIR0, OP_DIR1, OP_DIR2,
        OP_E1_0, OP_E1_1, OP_E1_2,
        OP_E2_0, OP_E2_1, OP_E2_2,
        OP_S0, OP_S1, OP_S2,
        OP_H0, OP_H1, OP_H2,
        OP_Q0, OP_Q1, OP_Q2
    } opnd_t;

    typedef enum logic [3:0] {
        D_H0, D_H1, D_H2, D_DET, D_Q0, D_Q1, D_Q2, D_NU, D_NV, D_NT
    } dest_t;

    typedef struct packed {
        opnd_t    a;
        opnd_t    b;
        mac_ctl_t ctl;
        dest_t    dst;
    } uop_t;

    localparam mac_ctl_t C_FIRST = '{neg: 1'b0, first: 1'b1, last: 1'b0};
    localparam mac_ctl_t C_MID   = '{neg: 1'b0, first: 1'b0, last: 1'b0};
    localparam mac_ctl_t C_LAST  = '{neg: 1'b0, first: 1'b0, last: 1'b1};
    localparam mac_ctl_t C_NLAST = '{neg: 1'b1, first: 1'b0, last: 1'b1};

    // h = dir x e2, det = e1.h, q = s x e1, nu = s.h, nv = dir.q, nt = e2.q
    function automatic uop_t uop_at(input logic [STEP_W-1:0] step);
        uop_t u;
        case (step)
            5'd0:  u = '{OP_DIR1, OP_E2_2, C_FIRST, D_H0};
            5'd1:  u = '{OP_DIR2, OP_E2_1, C_NLAST, D_H0};
            5'd2:  u = '{OP_DIR2, OP_E2_0, C_FIRST, D_H1};
            5'd3:  u = '{OP_DIR0, OP_E2_2, C_NLAST, D_H1};
            5'd4:  u = '{OP_DIR0, OP_E2_1, C_FIRST, D_H2};
            5'd5:  u = '{OP_DIR1, OP_E2_0, C_NLAST, D_H2};
            5'd6:  u = '{OP_E1_0, OP_H0,   C_FIRST, D_DET};
            5'd7:  u = '{OP_E1_1, OP_H1,   C_MID,   D_DET};
            5'd8:  u = '{OP_E1_2, OP_H2,   C_LAST,  D_DET};
            5'd9:  u = '{OP_S1,   OP_E1_2, C_FIRST, D_Q0};
            5'd10: u = '{OP_S2,   OP_E1_1, C_NLAST, D_Q0};
            5'd11: u = '{OP_S2,   OP_E1_0, C_FIRST, D_Q1};
            5'd12: u = '{OP_S0,   OP_E1_2, C_NLAST, D_Q1};
            5'd13: u = '{OP_S0,   OP_E1_1, C_FIRST, D_Q2};
            5'd14: u = '{OP_S1,   OP_E1_0, C_NLAST, D_Q2};
            5'd15: u = '{OP_S0,   OP_H0,   C_FIRST, D_NU};
            5'd16: u = '{OP_S1,   OP_H1,   C_MID,   D_NU};
            5'd17: u = '{OP_S2,   OP_H2,   C_LAST,  D_NU};
            5'd18: u = '{OP_DIR0, OP_Q0,   C_FIRST, D_NV};
            5'd19: u = '{OP_DIR1, OP_Q1,   C_MID,   D_NV};
            5'd20: u = '{OP_DIR2, OP_Q2,   C_LAST,  D_NV};
            5'd21: u = '{OP_E2_0, OP_Q0,   C_FIRST, D_NT};
            5'd22: u = '{OP_E2_1, OP_Q1,   C_MID,   D_NT};
            5'd23: u = '{OP_E2_2, OP_Q2,   C_LAST,  D_NT};
            default: u = '{OP_DIR0, OP_DIR0, C_MID, D_H0};
        endcase
        return u;
    endfunction

    // Saturating 33-bit signed difference to 32 bits
    function automatic logic signed [WORD_W-1:0] sat_sub(
        input logic signed [WORD_W-1:0] x,
        input logic signed [WORD_W-1:0] y);
        logic signed [WORD_W:0] d;
        logic signed [WORD_W-1:0] r;
        d = {x[WORD_W-1], x} - {y[WORD_W-1], y};
        if (d[WORD_W] != d[WORD_W-1])
            r = d[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        else
            r = d[WORD_W-1:0];
        return r;
    endfunction

endpackage

// ===== hw/rtl/rtnh_mac.sv =====
// Shared multiply-accumulate unit: one 32x32 multiply, floor rescale, running sum.
// Depends on rtnh_pkg. Product registered on issue, accumulated the next cycle.
module rtnh_mac
    import rtnh_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     issue,
    input  logic signed [WORD_W-1:0] op_a,
    input  logic signed [WORD_W-1:0] op_b,
    input  mac_ctl_t                 ctl,
    output logic                     done,
    output logic signed [WORD_W-1:0] result
);

    logic signed [2*WORD_W-1:0] prod_reg;
    logic signed [2*WORD_W-1:0] shifted;
    logic signed [ACC_W-1:0]    term;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_sum;
    mac_ctl_t                   ctl_reg;
    logic                       acc_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_en_reg <= 1'b0;
        end
        else
        begin
            acc_en_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            prod_reg <= op_a * op_b;
            ctl_reg  <= ctl;
        end
        if (acc_en_reg)
        begin
            acc_reg <= acc_sum;
        end
    end

    // arithmetic shift rounds toward minus infinity
    assign shifted = prod_reg >>> FRACTION_BITS;
    assign term    = {{(ACC_W-2*WORD_W){shifted[2*WORD_W-1]}}, shifted};
    assign acc_sum = (ctl_reg.first ? '0 : acc_reg) + (ctl_reg.neg ? -term : term);

    always_comb
    begin
        if (acc_sum[ACC_W-1:WORD_W-1] != '0 && acc_sum[ACC_W-1:WORD_W-1] != '1)
            result = acc_sum[ACC_W-1] ? {1'b1, {(WORD_W-1){1'b0}}}
                                      : {1'b0, {(WORD_W-1){1'b1}}};
        else
            result = acc_sum[WORD_W-1:0];
    end

    assign done = acc_en_reg && ctl_reg.last;

endmodule

// ===== hw/rtl/rtnh_div.sv =====
// Restoring divider, one quotient bit per cycle: (num << FRACTION_BITS) / den.
// Depends on rtnh_pkg. den must be nonzero.
module rtnh_div
    import rtnh_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [WORD_W-1:0]             num,
    input  logic [WORD_W-1:0]             den,
    output logic                          done,
    output logic [WORD_W+FRACTION_BITS-1:0] quot
);

    localparam int DW  = WORD_W + FRACTION_BITS;
    localparam int CW  = $clog2(DW + 1);

    logic [WORD_W-1:0] den_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [DW-1:0]     dq_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [WORD_W:0]   rem_s;
    logic [WORD_W:0]   rem_d;
    logic              q_bit;

    assign rem_s = {rem_reg, dq_reg[DW-1]};
    assign rem_d = rem_s - {1'b0, den_reg};
    assign q_bit = !rem_d[WORD_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            rem_reg <= '0;
            dq_reg  <= {num, {FRACTION_BITS{1'b0}}};
        end
        else if (busy_reg)
        begin
            rem_reg <= q_bit ? rem_d[WORD_W-1:0] : rem_s[WORD_W-1:0];
            dq_reg  <= {dq_reg[DW-2:0], q_bit};
        end
    end

    assign done = done_reg;
    assign quot = dq_reg;

endmodule

// ===== hw/rtl/ray_triangle_nearest_hit_top.sv =====
// Ray/triangle nearest-hit block: sequencer, operand registers and result tracking.
// Depends on rtnh_pkg, rtnh_mac (shared multiply-accumulate), rtnh_div (divider).
//
// Usage:
//   Program the ray over the write port (cfg_we, cfg_index, cfg_data) while idle:
//   origin x/y/z, direction x/y/z, max distance, epsilon, in that index order.
//   Send triangles on tri_valid/tri_data; a transfer happens when tri_valid is
//   high and tri_stall is low. One result transfer per triangle leaves on
//   res_valid/res_data under res_stall.
//   A skipped triangle goes straight from its transfer to the output state. A
//   tested triangle runs 24 multiply-accumulate ops on the single shared
//   multiplier, then up to three divisions with 32+FRACTION_BITS quotient bits
//   each on the shared divider; a parallel ray ends after the determinant and
//   a miss caught by the sign test ends before the divisions. One triangle is
//   in work at a time and the next is taken in the cycle after the result
//   loads.
//   The result register frees the input side: the next triangle is taken while
//   the previous result still waits under res_stall; a finished result waits in
//   its final state until the register empties.
//   Reset loads the ray defaults (direction straight down, max distance at its
//   top, epsilon one LSB) and clears the nearest-hit tracking and the counter.
//   After a batch_end triangle the tracking and counter return to reset values.
module ray_triangle_nearest_hit_top
    import rtnh_pkg::*;
#(
    parameter int INDEX_BITS    = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tri_valid,
    output logic              tri_stall,
    input  tri_t              tri_data,
    output logic              res_valid,
    input  logic              res_stall,
    output res_t              res_data,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [WORD_W-1:0] cfg_data
);

    localparam int DW = WORD_W + FRACTION_BITS;
    localparam logic [DW:0] ONE_Q = (DW+1)'(1) << FRACTION_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_MAC, S_DET, S_FOLD, S_DGO, S_DWAIT, S_OUT
    } state_t;

    // ray registers
    logic signed [WORD_W-1:0] org_reg [3];
    logic signed [WORD_W-1:0] dir_reg [3];
    logic [DIST_W-1:0]        max_dist_reg;
    logic [EPS_W-1:0]         eps_reg;

    // per-triangle working values
    logic signed [WORD_W-1:0] e1_reg [3];
    logic signed [WORD_W-1:0] e2_reg [3];
    logic signed [WORD_W-1:0] s_reg  [3];
    logic signed [WORD_W-1:0] h_reg  [3];
    logic signed [WORD_W-1:0] q_reg  [3];
    logic signed [WORD_W-1:0] det_reg;
    logic signed [WORD_W-1:0] nu_reg;
    logic signed [WORD_W-1:0] nv_reg;
    logic signed [WORD_W-1:0] nt_reg;
    logic [WORD_W-1:0]        den_reg;
    logic [WORD_W-1:0]        num_reg [3];
    logic [DW-1:0]            qu_reg;
    logic [DW-1:0]            qv_reg;
    logic [DW-1:0]            qt_reg;
    logic                     cand_reg;
    logic                     batch_end_reg;

    // control and tracking
    state_t                   state_reg;
    logic [STEP_W-1:0]        step_reg;
    logic                     phase_reg;
    logic [1:0]               div_sel_reg;
    logic [DIST_W-1:0]        best_dist_reg;
    logic                     best_valid_reg;
    logic [INDEX_BITS-1:0]    best_pos_reg;
    logic [INDEX_BITS-1:0]    count_reg;
    logic                     res_valid_reg;
    res_t                     res_data_reg;

    uop_t                     uop;
    logic signed [WORD_W-1:0] op_a;
    logic signed [WORD_W-1:0] op_b;
    logic                     mac_issue;
    logic                     mac_done;
    logic signed [WORD_W-1:0] mac_result;
    logic                     div_start;
    logic                     div_done;
    logic [DW-1:0]            div_quot;

    logic                     tri_take;
    logic                     out_free;
    logic [WORD_W-1:0]        abs_det;
    logic                     parallel;
    logic                     det_neg;
    logic signed [WORD_W:0]   nu_f;
    logic signed [WORD_W:0]   nv_f;
    logic signed [WORD_W:0]   nt_f;
    logic [DIST_W-1:0]        qt_sat;
    logic [DW:0]              uv_sum;
    logic                     hit;
    logic                     upd;
    logic [INDEX_BITS+OUT_IDX_W-1:0] pos_ext;

    assign tri_stall = (state_reg != S_IDLE);
    assign tri_take  = tri_valid && !tri_stall;
    assign out_free  = !res_valid_reg || !res_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg[0]   <= '0;
            org_reg[1]   <= '0;
            org_reg[2]   <= '0;
            dir_reg[0]   <= '0;
            dir_reg[1]   <= 32'shFFFF_0000;
            dir_reg[2]   <= '0;
            max_dist_reg <= DIST_MAX;
            eps_reg      <= 16'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ORIGIN_X: org_reg[0]   <= cfg_data;
                REG_ORIGIN_Y: org_reg[1]   <= cfg_data;
                REG_ORIGIN_Z: org_reg[2]   <= cfg_data;
                REG_DIR_X:    dir_reg[0]   <= cfg_data;
                REG_DIR_Y:    dir_reg[1]   <= cfg_data;
                REG_DIR_Z:    dir_reg[2]   <= cfg_data;
                REG_MAX_DIST: max_dist_reg <= cfg_data[DIST_W-1:0];
                REG_EPSILON:  eps_reg      <= cfg_data[EPS_W-1:0];
                default:      eps_reg      <= eps_reg;
            endcase
        end
    end

    // operand selection for the shared multiplier
    function automatic logic signed [WORD_W-1:0] pick(
        input opnd_t sel,
        input logic signed [WORD_W-1:0] d0, input logic signed [WORD_W-1:0] d1,
        input logic signed [WORD_W-1:0] d2, input logic signed [WORD_W-1:0] a0,
        input logic signed [WORD_W-1:0] a1, input logic signed [WORD_W-1:0] a2,
        input logic signed [WORD_W-1:0] b0, input logic signed [WORD_W-1:0] b1,
        input logic signed [WORD_W-1:0] b2, input logic signed [WORD_W-1:0] c0,
        input logic signed [WORD_W-1:0] c1, input logic signed [WORD_W-1:0] c2,
        input logic signed [WORD_W-1:0] g0, input logic signed [WORD_W-1:0] g1,
        input logic signed [WORD_W-1:0] g2, input logic signed [WORD_W-1:0] k0,
        input logic signed [WORD_W-1:0] k1, input logic signed [WORD_W-1:0] k2);
        logic signed [WORD_W-1:0] r;
        case (sel)
            OP_DIR0: r = d0;
            OP_DIR1: r = d1;
            OP_DIR2: r = d2;
            OP_E1_0: r = a0;
            OP_E1_1: r = a1;
            OP_E1_2: r = a2;
            OP_E2_0: r = b0;
            OP_E2_1: r = b1;
            OP_E2_2: r = b2;
            OP_S0:   r = c0;
            OP_S1:   r = c1;
            OP_S2:   r = c2;
            OP_H0:   r = g0;
            OP_H1:   r = g1;
            OP_H2:   r = g2;
            OP_Q0:   r = k0;
            OP_Q1:   r = k1;
            OP_Q2:   r = k2;
            default: r = '0;
        endcase
        return r;
    endfunction

    assign uop  = uop_at(step_reg);
    assign op_a = pick(uop.a, dir_reg[0], dir_reg[1], dir_reg[2], e1_reg[0], e1_reg[1],
                       e1_reg[2], e2_reg[0], e2_reg[1], e2_reg[2], s_reg[0], s_reg[1],
                       s_reg[2], h_reg[0], h_reg[1], h_reg[2], q_reg[0], q_reg[1], q_reg[2]);
    assign op_b = pick(uop.b, dir_reg[0], dir_reg[1], dir_reg[2], e1_reg[0], e1_reg[1],
                       e1_reg[2], e2_reg[0], e2_reg[1], e2_reg[2], s_reg[0], s_reg[1],
                       s_reg[2], h_reg[0], h_reg[1], h_reg[2], q_reg[0], q_reg[1], q_reg[2]);
    assign mac_issue = (state_reg == S_MAC) && !phase_reg;

    rtnh_mac #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .issue  (mac_issue),
        .op_a   (op_a),
        .op_b   (op_b),
        .ctl    (uop.ctl),
        .done   (mac_done),
        .result (mac_result)
    );

    assign div_start = (state_reg == S_DGO);

    rtnh_div #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg[div_sel_reg]),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // parallel test and sign folding so the determinant is positive
    assign det_neg  = det_reg[WORD_W-1];
    assign abs_det  = det_neg ? -det_reg : det_reg;
    assign parallel = (det_reg == '0) || (abs_det < {{(WORD_W-EPS_W){1'b0}}, eps_reg});
    assign nu_f = det_neg ? -{nu_reg[WORD_W-1], nu_reg} : {nu_reg[WORD_W-1], nu_reg};
    assign nv_f = det_neg ? -{nv_reg[WORD_W-1], nv_reg} : {nv_reg[WORD_W-1], nv_reg};
    assign nt_f = det_neg ? -{nt_reg[WORD_W-1], nt_reg} : {nt_reg[WORD_W-1], nt_reg};

    // hit decision and nearest rule
    assign qt_sat = (|qt_reg[DW-1:DIST_W]) ? DIST_MAX : qt_reg[DIST_W-1:0];
    assign uv_sum = {1'b0, qu_reg} + {1'b0, qv_reg};
    assign hit = cand_reg && ({1'b0, qu_reg} <= ONE_Q) && (uv_sum <= ONE_Q)
              && (qt_sat > {{(DIST_W-EPS_W){1'b0}}, eps_reg});
    assign upd = hit && (qt_sat <= max_dist_reg)
              && (!best_valid_reg || (qt_sat < best_dist_reg));
    assign pos_ext = {{OUT_IDX_W{1'b0}}, (upd ? count_reg : best_pos_reg)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= '0;
            phase_reg      <= 1'b0;
            div_sel_reg    <= '0;
            cand_reg       <= 1'b0;
            best_dist_reg  <= DIST_MAX;
            best_valid_reg <= 1'b0;
            best_pos_reg   <= '0;
            count_reg      <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            // drop the result once the receiver takes it, unless a new one loads
            if (res_valid_reg && !res_stall && (state_reg != S_OUT))
                res_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (tri_take)
                    begin
                        cand_reg  <= 1'b0;
                        step_reg  <= '0;
                        phase_reg <= 1'b0;
                        state_reg <= tri_data.skip_triangle ? S_OUT : S_MAC;
                    end
                end
                S_MAC:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        if (step_reg == STEP_DET_LAST)
                            state_reg <= S_DET;
                        else if (step_reg == STEP_LAST)
                            state_reg <= S_FOLD;
                        else
                            step_reg <= step_reg + 1'b1;
                    end
                end
                S_DET:
                begin
                    if (parallel)
                        state_reg <= S_OUT;
                    else
                    begin
                        step_reg  <= STEP_Q_FIRST;
                        phase_reg <= 1'b0;
                        state_reg <= S_MAC;
                    end
                end
                S_FOLD:
                begin
                    div_sel_reg <= '0;
                    if (!nu_f[WORD_W] && !nv_f[WORD_W] && !nt_f[WORD_W] && (nt_f != '0))
                        state_reg <= S_DGO;
                    else
                        state_reg <= S_OUT;
                end
                S_DGO:
                begin
                    state_reg <= S_DWAIT;
                end
                S_DWAIT:
                begin
                    if (div_done)
                    begin
                        if (div_sel_reg == 2'd2)
                        begin
                            cand_reg  <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            div_sel_reg <= div_sel_reg + 1'b1;
                            state_reg   <= S_DGO;
                        end
                    end
                end
                S_OUT:
                begin
                    // hold until the result register is free
                    if (out_free)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        if (batch_end_reg)
                        begin
                            best_dist_reg  <= DIST_MAX;
                            best_valid_reg <= 1'b0;
                            best_pos_reg   <= '0;
                            count_reg      <= '0;
                        end
                        else
                        begin
                            count_reg <= count_reg + 1'b1;
                            if (upd)
                            begin
                                best_dist_reg  <= qt_sat;
                                best_valid_reg <= 1'b1;
                                best_pos_reg   <= count_reg;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (tri_take)
        begin
            batch_end_reg <= tri_data.batch_end;
            e1_reg[0] <= sat_sub(tri_data.b_x, tri_data.a_x);
            e1_reg[1] <= sat_sub(tri_data.b_y, tri_data.a_y);
            e1_reg[2] <= sat_sub(tri_data.b_z, tri_data.a_z);
            e2_reg[0] <= sat_sub(tri_data.c_x, tri_data.a_x);
            e2_reg[1] <= sat_sub(tri_data.c_y, tri_data.a_y);
            e2_reg[2] <= sat_sub(tri_data.c_z, tri_data.a_z);
            s_reg[0]  <= sat_sub(org_reg[0], tri_data.a_x);
            s_reg[1]  <= sat_sub(org_reg[1], tri_data.a_y);
            s_reg[2]  <= sat_sub(org_reg[2], tri_data.a_z);
        end
        if ((state_reg == S_MAC) && mac_done)
        begin
            case (uop.dst)
                D_H0:  h_reg[0] <= mac_result;
                D_H1:  h_reg[1] <= mac_result;
                D_H2:  h_reg[2] <= mac_result;
                D_DET: det_reg  <= mac_result;
                D_Q0:  q_reg[0] <= mac_result;
                D_Q1:  q_reg[1] <= mac_result;
                D_Q2:  q_reg[2] <= mac_result;
                D_NU:  nu_reg   <= mac_result;
                D_NV:  nv_reg   <= mac_result;
                D_NT:  nt_reg   <= mac_result;
                default: nt_reg <= nt_reg;
            endcase
        end
        if (state_reg == S_FOLD)
        begin
            den_reg    <= abs_det;
            num_reg[0] <= nu_f[WORD_W-1:0];
            num_reg[1] <= nv_f[WORD_W-1:0];
            num_reg[2] <= nt_f[WORD_W-1:0];
        end
        if ((state_reg == S_DWAIT) && div_done)
        begin
            case (div_sel_reg)
                2'd0:    qu_reg <= div_quot;
                2'd1:    qv_reg <= div_quot;
                default: qt_reg <= div_quot;
            endcase
        end
        if ((state_reg == S_OUT) && out_free)
        begin
            res_data_reg.tri_hit          <= hit;
            res_data_reg.tri_distance     <= hit ? qt_sat : '0;
            res_data_reg.tri_u            <= hit ? qu_reg[BARY_W-1:0] : '0;
            res_data_reg.tri_v            <= hit ? qv_reg[BARY_W-1:0] : '0;
            res_data_reg.nearest_updated  <= upd;
            res_data_reg.nearest_found    <= best_valid_reg || upd;
            res_data_reg.nearest_distance <= upd ? qt_sat : best_dist_reg;
            res_data_reg.nearest_index    <= pos_ext[OUT_IDX_W-1:0];
            res_data_reg.batch_done       <= batch_end_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

// ===== hw/rtl/rtnh_checker.sv =====
// Port-level checks for the ray/triangle nearest-hit block, bound to the top level.
// Depends on rtnh_pkg and ray_triangle_nearest_hit_top.
module rtnh_checker
    import rtnh_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic res_valid,
    input logic res_stall,
    input res_t res_data
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.tri_hit |->
            res_data.tri_distance == '0 && res_data.tri_u == '0 && res_data.tri_v == '0)
        else $error("miss carries nonzero hit fields");

    a_update: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.nearest_updated |->
            res_data.tri_hit && res_data.nearest_found
            && res_data.nearest_distance == res_data.tri_distance)
        else $error("nearest update inconsistent with hit");

    a_none_found: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.nearest_found |->
            res_data.nearest_distance == DIST_MAX && res_data.nearest_index == '0)
        else $error("empty tracking shows a distance or index");

endmodule

bind ray_triangle_nearest_hit_top rtnh_checker u_rtnh_checker (.*);
